// File: rtl/core/salc_pkg.sv
// Shared types, codes and helpers for the set-associative LRU cache model.
`timescale 1ns / 1ps
package salc_pkg;

  localparam int STAMP_W = 64;
  localparam int TOTAL_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_INSTR  = 2'd3
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [5:0] block_bits;
    logic [3:0] ways;
  } cfg_t;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    sat_inc = (v == '1) ? v : v + TOTAL_W'(1);
  endfunction

endpackage

// File: rtl/core/salc_front.sv
// Front end: accepts trace words, clamps the configuration and splits the address.
`timescale 1ns / 1ps
module salc_front import salc_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64,
  localparam int SET_W = MAX_SET_BITS,
  localparam int TAG_W = ADDR_WIDTH - 2,
  localparam int NW_W  = $clog2(MAX_WAYS + 1)
) (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       cmd_i,
  input  logic [63:0]      address_i,
  input  cfg_t             cfg_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output logic [1:0]       q_cmd_o,
  output logic [NW_W-1:0]  q_nw_o,
  output logic [SET_W-1:0] q_set_o,
  output logic [TAG_W-1:0] q_tag_o
);

  localparam int SB_W = $clog2(MAX_SET_BITS + 1);

  logic [SB_W-1:0]       sb;
  logic [5:0]            bb;
  logic [6:0]            sh;
  logic [ADDR_WIDTH-1:0] addr;
  logic [SET_W-1:0]      set_raw;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_cmd_o    = cmd_i;
  assign addr       = address_i[ADDR_WIDTH-1:0];

  always_comb begin
    if (cfg_i.set_bits == 3'd0) begin
      sb = SB_W'(1);
    end else if (int'(cfg_i.set_bits) > MAX_SET_BITS) begin
      sb = SB_W'(MAX_SET_BITS);
    end else begin
      sb = SB_W'(cfg_i.set_bits);
    end
    if (cfg_i.block_bits == 6'd0) begin
      bb = 6'd1;
    end else if (cfg_i.block_bits > 6'd32) begin
      bb = 6'd32;
    end else begin
      bb = cfg_i.block_bits;
    end
    if (cfg_i.ways == 4'd0) begin
      q_nw_o = NW_W'(1);
    end else if (int'(cfg_i.ways) > MAX_WAYS) begin
      q_nw_o = NW_W'(MAX_WAYS);
    end else begin
      q_nw_o = NW_W'(cfg_i.ways);
    end
  end

  assign sh      = 7'(sb) + 7'(bb);
  assign q_tag_o = TAG_W'(addr >> sh);
  assign set_raw = SET_W'(addr >> bb);

  // keep only the configured number of set index bits
  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      q_set_o[i] = set_raw[i] && (i < int'(sb));
    end
  end

endmodule

// File: rtl/core/salc_fifo.sv
// Two-entry queue between the front end and the lookup engine.
`timescale 1ns / 1ps
module salc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] head_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/salc_back.sv
// Lookup engine: set memory, LRU victim choice, running totals and result register.
`timescale 1ns / 1ps
module salc_back import salc_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64,
  localparam int SET_W = MAX_SET_BITS,
  localparam int TAG_W = ADDR_WIDTH - 2,
  localparam int NW_W  = $clog2(MAX_WAYS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  logic [1:0]         q_cmd_i,
  input  logic [NW_W-1:0]    q_nw_i,
  input  logic [SET_W-1:0]   q_set_i,
  input  logic [TAG_W-1:0]   q_tag_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         hits_now_o,
  output logic               misses_now_o,
  output logic               evicted_now_o,
  output logic [TOTAL_W-1:0] hit_total_o,
  output logic [TOTAL_W-1:0] miss_total_out_o,
  output logic [TOTAL_W-1:0] eviction_total_out_o
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_WR   = 2'd3;

  logic [MAX_WAYS-1:0]                valid_mem [NUM_SETS];
  logic [MAX_WAYS-1:0][TAG_W-1:0]     tag_mem   [NUM_SETS];
  logic [MAX_WAYS-1:0][STAMP_W-1:0]   stamp_mem [NUM_SETS];
  logic [NUM_SETS-1:0]                row_init_q;

  logic [1:0]                         state_q, state_d;
  logic [1:0]                         cmd_q;
  logic [NW_W-1:0]                    nw_q;
  logic [SET_W-1:0]                   set_q;
  logic [TAG_W-1:0]                   tag_q;
  logic                               row_live_q;
  logic [MAX_WAYS-1:0]                vrow_q;
  logic [MAX_WAYS-1:0][TAG_W-1:0]     trow_q;
  logic [MAX_WAYS-1:0][STAMP_W-1:0]   srow_q;
  logic [MAX_WAYS-1:0]                vrow;
  logic [MAX_WAYS-1:0][TAG_W-1:0]     trow;
  logic [MAX_WAYS-1:0][STAMP_W-1:0]   srow;
  logic [MAX_WAYS-1:0]                match_q, match_d;
  logic [MAX_WAYS-1:0][MAX_WAYS-1:0]  lt_q, lt_d;
  logic [MAX_WAYS-1:0]                cand;
  logic                               hit;
  logic [WAY_W-1:0]                   hit_way, victim, way;
  logic                               evict;
  logic                               is_mod, is_instr;
  logic                               wr_fire, wr_mem;
  logic [STAMP_W-1:0]                 stamp_cnt_q, stamp_cnt_d, stamp_new;
  logic [MAX_WAYS-1:0]                nvrow;
  logic [MAX_WAYS-1:0][TAG_W-1:0]     ntrow;
  logic [MAX_WAYS-1:0][STAMP_W-1:0]   nsrow;
  logic [TOTAL_W-1:0]                 hits_q, hits_d, misses_q, misses_d, evicts_q, evicts_d;
  logic                               out_valid_q, out_valid_d;
  logic [1:0]                         hits_now_q, hits_now_d;
  logic                               misses_now_q, misses_now_d;
  logic                               evicted_now_q, evicted_now_d;

  assign is_mod   = (cmd_q == CMD_MODIFY);
  assign is_instr = (cmd_q == CMD_INSTR);
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;
  assign wr_fire  = (state_q == ST_WR) && !(out_valid_q && out_stall_i);
  assign wr_mem   = wr_fire && !is_instr;

  // a set never written reads as all zero
  assign vrow = row_live_q ? vrow_q : '0;
  assign trow = row_live_q ? trow_q : '0;
  assign srow = row_live_q ? srow_q : '0;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      match_d[i] = vrow[i] && (trow[i] == tag_q) && (i < int'(nw_q));
      for (int j = 0; j < MAX_WAYS; j++) begin
        lt_d[i][j] = srow[i] < srow[j];
      end
    end
  end

  // victim: lowest way whose stamp is minimal among the ways in use
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      cand[w] = (w < int'(nw_q));
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (j < int'(nw_q) && j != w) begin
          if (j < w) begin
            cand[w] = cand[w] && lt_q[w][j];
          end else begin
            cand[w] = cand[w] && !lt_q[j][w];
          end
        end
      end
    end
    hit_way = '0;
    victim  = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match_q[w]) begin
        hit_way = WAY_W'(w);
      end
      if (cand[w]) begin
        victim = WAY_W'(w);
      end
    end
  end

  assign hit       = |match_q;
  assign way       = hit ? hit_way : victim;
  assign evict     = !hit && vrow[victim];
  assign stamp_new = is_mod ? stamp_cnt_q + STAMP_W'(1) : stamp_cnt_q;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      nvrow[w] = vrow[w] || (WAY_W'(w) == way);
      ntrow[w] = (WAY_W'(w) == way && !hit) ? tag_q : trow[w];
      nsrow[w] = (WAY_W'(w) == way) ? stamp_new : srow[w];
    end
  end

  always_comb begin
    state_d       = state_q;
    stamp_cnt_d   = stamp_cnt_q;
    hits_d        = hits_q;
    misses_d      = misses_q;
    evicts_d      = evicts_q;
    hits_now_d    = hits_now_q;
    misses_now_d  = misses_now_q;
    evicted_now_d = evicted_now_q;
    out_valid_d   = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = ST_RD;
        end
      end
      ST_RD:  state_d = ST_CMP;
      ST_CMP: state_d = ST_WR;
      ST_WR: begin
        if (wr_fire) begin
          state_d       = ST_IDLE;
          out_valid_d   = 1'b1;
          hits_now_d    = 2'd0;
          misses_now_d  = 1'b0;
          evicted_now_d = 1'b0;
          if (!is_instr) begin
            stamp_cnt_d = stamp_cnt_q + (is_mod ? STAMP_W'(2) : STAMP_W'(1));
            if (hit) begin
              hits_now_d = is_mod ? 2'd2 : 2'd1;
              hits_d     = is_mod ? sat_inc(sat_inc(hits_q)) : sat_inc(hits_q);
            end else begin
              hits_now_d    = is_mod ? 2'd1 : 2'd0;
              hits_d        = is_mod ? sat_inc(hits_q) : hits_q;
              misses_now_d  = 1'b1;
              misses_d      = sat_inc(misses_q);
              evicted_now_d = evict;
              evicts_d      = evict ? sat_inc(evicts_q) : evicts_q;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      row_init_q    <= '0;
      row_live_q    <= 1'b0;
      stamp_cnt_q   <= STAMP_W'(1);
      hits_q        <= '0;
      misses_q      <= '0;
      evicts_q      <= '0;
      out_valid_q   <= 1'b0;
      hits_now_q    <= 2'd0;
      misses_now_q  <= 1'b0;
      evicted_now_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      stamp_cnt_q   <= stamp_cnt_d;
      hits_q        <= hits_d;
      misses_q      <= misses_d;
      evicts_q      <= evicts_d;
      out_valid_q   <= out_valid_d;
      hits_now_q    <= hits_now_d;
      misses_now_q  <= misses_now_d;
      evicted_now_q <= evicted_now_d;
      if (q_pop_o) begin
        row_live_q <= row_init_q[q_set_i];
      end
      if (wr_mem) begin
        row_init_q[set_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q  <= q_cmd_i;
      nw_q   <= q_nw_i;
      set_q  <= q_set_i;
      tag_q  <= q_tag_i;
      vrow_q <= valid_mem[q_set_i];
      trow_q <= tag_mem[q_set_i];
      srow_q <= stamp_mem[q_set_i];
    end
    if (state_q == ST_RD) begin
      match_q <= match_d;
      lt_q    <= lt_d;
    end
    if (wr_mem) begin
      valid_mem[set_q] <= nvrow;
      tag_mem[set_q]   <= ntrow;
      stamp_mem[set_q] <= nsrow;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign hits_now_o           = hits_now_q;
  assign misses_now_o         = misses_now_q;
  assign evicted_now_o        = evicted_now_q;
  assign hit_total_o          = hits_q;
  assign miss_total_out_o     = misses_q;
  assign eviction_total_out_o = evicts_q;

endmodule

// File: rtl/core/set_assoc_lru_cache_model_top.sv
// An accepted word is queued, popped only in the idle state, then runs one read,
// compare, write pass over one set row of the line memory; a modify does both
// accesses in that pass; its result is registered when no output stall holds it.
// Reset clears totals and per-set valid flags and sets the configuration and the
// stamp counter to one at once; no clearing pass over the line memory is needed.
`timescale 1ns / 1ps
module set_assoc_lru_cache_model_top import salc_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            cmd_i,
  input  logic [63:0]           address_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            hits_now_o,
  output logic                  misses_now_o,
  output logic                  evicted_now_o,
  output logic [TOTAL_W-1:0]    hit_total_o,
  output logic [TOTAL_W-1:0]    miss_total_out_o,
  output logic [TOTAL_W-1:0]    eviction_total_out_o
);

  localparam int SET_W = MAX_SET_BITS;
  localparam int TAG_W = ADDR_WIDTH - 2;
  localparam int NW_W  = $clog2(MAX_WAYS + 1);
  localparam int ENT_W = 2 + NW_W + SET_W + TAG_W;

  cfg_t             cfg_q;
  logic             q_full, q_empty, q_push, q_pop;
  logic [1:0]       f_cmd, b_cmd;
  logic [NW_W-1:0]  f_nw, b_nw;
  logic [SET_W-1:0] f_set, b_set;
  logic [TAG_W-1:0] f_tag, b_tag;
  logic [ENT_W-1:0] q_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits   <= 3'd1;
      cfg_q.block_bits <= 6'd1;
      cfg_q.ways       <= 4'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SET_BITS:   cfg_q.set_bits   <= cfg_data_i[2:0];
        CFG_BLOCK_BITS: cfg_q.block_bits <= cfg_data_i;
        CFG_WAYS:       cfg_q.ways       <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  salc_front #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS(MAX_WAYS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .cmd_i(cmd_i),
    .address_i(address_i),
    .cfg_i(cfg_q),
    .q_full_i(q_full),
    .q_push_o(q_push),
    .q_cmd_o(f_cmd),
    .q_nw_o(f_nw),
    .q_set_o(f_set),
    .q_tag_o(f_tag)
  );

  salc_fifo #(
    .WIDTH(ENT_W)
  ) u_fifo (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .push_data_i({f_cmd, f_nw, f_set, f_tag}),
    .full_o(q_full),
    .pop_i(q_pop),
    .empty_o(q_empty),
    .head_o(q_head)
  );

  assign {b_cmd, b_nw, b_set, b_tag} = q_head;

  salc_back #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS(MAX_WAYS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .q_empty_i(q_empty),
    .q_cmd_i(b_cmd),
    .q_nw_i(b_nw),
    .q_set_i(b_set),
    .q_tag_i(b_tag),
    .q_pop_o(q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .hits_now_o(hits_now_o),
    .misses_now_o(misses_now_o),
    .evicted_now_o(evicted_now_o),
    .hit_total_o(hit_total_o),
    .miss_total_out_o(miss_total_out_o),
    .eviction_total_out_o(eviction_total_out_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_now_o |-> misses_now_o)
    else $error("eviction reported without a miss");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hits_now_o == 2'd2 |-> !misses_now_o && !evicted_now_o)
    else $error("double hit reported together with a miss");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule
